>>> hw/rtl/u8d_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
package u8d_pkg;

   localparam int unsigned ByteWidth = 8;
   localparam int unsigned CpWidth   = 22;
   localparam int unsigned PayWidth  = 6;

   typedef enum logic [1:0] {
      STATUS_OK  = 2'd0,
      STATUS_BAD = 2'd1,
      STATUS_END = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]         bytes_left;
      logic [CpWidth-1:0] accumulator;
      logic               bad_seen;
   } dec_state_type;

   typedef struct packed {
      logic               emit;
      logic [CpWidth-1:0] code_point;
      status_type         status;
   } dec_result_type;

endpackage

>>> hw/rtl/u8d_req_if.sv
// Byte input channel: valid, ready and one raw byte.
interface u8d_req_if import u8d_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ByteWidth-1:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

>>> hw/rtl/u8d_rsp_if.sv
// Result channel: valid, ready, code point and status.
interface u8d_rsp_if import u8d_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CpWidth-1:0] code_point;
   status_type         status;

   modport source (output valid, output code_point, output status, input ready);
   modport sink   (input valid, input code_point, input status, output ready);
endinterface

>>> hw/rtl/u8d_input_stage.sv
// Input register holding one accepted byte until the decoder takes it.
module u8d_input_stage import u8d_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [ByteWidth-1:0] req_byte,
   input  logic                 take,
   output logic                 byte_valid,
   output logic [ByteWidth-1:0] byte_data
);

   logic                 valid_ff;
   logic                 valid_in;
   logic [ByteWidth-1:0] data_ff;

   assign req_ready  = !valid_ff || take;
   assign valid_in   = req_ready ? req_valid : valid_ff;
   assign byte_valid = valid_ff;
   assign byte_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         data_ff <= req_byte;
      end
   end

endmodule

>>> hw/rtl/u8d_decode.sv
// Decode step: next sequence state and optional result for one byte.
module u8d_decode import u8d_pkg::*; (
   input  logic [ByteWidth-1:0] in_byte,
   input  dec_state_type        state,
   output dec_state_type        next_state,
   output dec_result_type       result
);

   logic [1:0] left_dec;
   logic       bad_next;

   always_comb begin
      left_dec = state.bytes_left - 2'd1;
      bad_next = state.bad_seen || (in_byte[7:6] != 2'b10);

      next_state = state;
      result.emit       = 1'b0;
      result.code_point = '0;
      result.status     = STATUS_OK;

      if (state.bytes_left == 2'd0) begin
         if (in_byte == '0) begin
            result.emit   = 1'b1;
            result.status = STATUS_END;
         end else if (!in_byte[7]) begin
            result.emit       = 1'b1;
            result.code_point = {{(CpWidth-ByteWidth){1'b0}}, in_byte};
         end else begin
            next_state.bad_seen = 1'b0;
            if (in_byte inside {[8'hC0:8'hDF]}) begin
               next_state.bytes_left  = 2'd1;
               next_state.accumulator = {{(CpWidth-5){1'b0}}, in_byte[4:0]};
            end else if (in_byte inside {[8'hE0:8'hEF]}) begin
               next_state.bytes_left  = 2'd2;
               next_state.accumulator = {{(CpWidth-4){1'b0}}, in_byte[3:0]};
            end else begin
               next_state.bytes_left  = 2'd3;
               next_state.accumulator = {{(CpWidth-4){1'b0}}, in_byte[3:0]};
            end
         end
      end else begin
         next_state.bytes_left  = left_dec;
         next_state.bad_seen    = bad_next;
         next_state.accumulator = {state.accumulator[CpWidth-PayWidth-1:0],
                                   in_byte[PayWidth-1:0]};
         if (left_dec == 2'd0) begin
            result.emit = 1'b1;
            if (bad_next) begin
               result.status = STATUS_BAD;
            end else begin
               result.code_point = next_state.accumulator;
            end
            next_state.accumulator = '0;
            next_state.bad_seen    = 1'b0;
         end
      end
   end

endmodule

>>> hw/rtl/utf8_stream_decoder.sv
// UTF-8 stream decoder top level.
//
// Bytes arrive on req_bus (valid/ready, field in_byte) and decoded results
// leave on rsp_bus (valid/ready, fields code_point and status). A byte is
// taken on every transfer; ASCII bytes, a zero byte in idle and the last
// byte of a multi-byte sequence each give one result, other bytes none.
// Status OK carries the code point, BAD marks a sequence with a broken
// continuation byte and END marks a zero byte; code_point is zero unless OK.
//
// The byte that completes a result is taken into the input register, then
// decoded into the result register; a stall can hold it in the input register.
// Throughput: one byte per cycle unless the result slot is blocked, set by
// the single decode step between the input register and the result register.
//
// Reset clears the sequence state and both valid flags. When the receiver
// stalls, the result register holds; bytes that give no result still pass,
// and req_bus.ready falls only once the input register holds a byte that
// needs the blocked result slot.
module utf8_stream_decoder import u8d_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   u8d_req_if.sink   req_bus,
   u8d_rsp_if.source rsp_bus
);

   logic                 byte_valid;
   logic [ByteWidth-1:0] byte_data;
   logic                 take;
   logic                 out_free;

   dec_state_type        state_ff;
   dec_state_type        state_in;
   dec_result_type       result;

   logic                 out_valid_ff;
   logic                 out_valid_in;
   logic [CpWidth-1:0]   out_cp_ff;
   status_type           out_status_ff;

   u8d_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_ready  (req_bus.ready),
      .req_byte   (req_bus.in_byte),
      .take       (take),
      .byte_valid (byte_valid),
      .byte_data  (byte_data)
   );

   u8d_decode u_decode (
      .in_byte    (byte_data),
      .state      (state_ff),
      .next_state (state_in),
      .result     (result)
   );

   assign out_free     = !out_valid_ff || rsp_bus.ready;
   assign take         = byte_valid && (out_free || !result.emit);
   assign out_valid_in = (take && result.emit) || (out_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (take) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && result.emit) begin
         out_cp_ff     <= result.code_point;
         out_status_ff <= result.status;
      end
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.code_point = out_cp_ff;
   assign rsp_bus.status     = out_status_ff;

endmodule

>>> hw/rtl/u8d_checker.sv
// Port-level checks for the UTF-8 stream decoder, bound to the top level.
module u8d_checker import u8d_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [CpWidth-1:0] rsp_code_point,
   input status_type         rsp_status
);

   a_reset_clears_output: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_cp_zero_unless_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_OK) |-> rsp_code_point == '0)
      else $error("code point not zero on non-ok status");

   a_result_needs_byte: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result without a byte transfer two cycles earlier");

   a_stalled_result_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_code_point) && $stable(rsp_status)))
      else $error("stalled result changed");

endmodule

bind utf8_stream_decoder u8d_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_code_point (rsp_bus.code_point),
   .rsp_status     (rsp_bus.status)
);
